// ===== sv/sexpr_byte_tokenizer_assert.svh =====
// Assertion helpers shared by the tokenizer modules.
`ifndef SEXPR_BYTE_TOKENIZER_ASSERT_SVH
`define SEXPR_BYTE_TOKENIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SXT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SXT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sxt_pkg.sv =====
package sxt_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRACKETS   = 3'd0,
		CFG_STRING_DLM = 3'd1,
		CFG_CHAR_DLM   = 3'd2,
		CFG_ESCAPE     = 3'd3,
		CFG_COMMENT    = 3'd4
	} cfg_idx_t;

	localparam logic [47:0] RST_BRACKETS   = 48'h7D7B5D5B2928;
	localparam logic [7:0]  RST_STRING_DLM = 8'h22;
	localparam logic [7:0]  RST_CHAR_DLM   = 8'h27;
	localparam logic [7:0]  RST_ESCAPE     = 8'h5C;
	localparam logic [7:0]  RST_COMMENT    = 8'h3B;
	localparam logic [7:0]  NEWLINE        = 8'h0A;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_ATOM    = 3'd1,
		MODE_LITERAL = 3'd2,
		MODE_COMMENT = 3'd3,
		MODE_DEAD    = 3'd4
	} mode_t;

	localparam logic [2:0] KIND_BRACKET = 3'd0;
	localparam logic [2:0] KIND_ATOM    = 3'd1;
	localparam logic [2:0] KIND_STRING  = 3'd2;
	localparam logic [2:0] KIND_CHAR    = 3'd3;
	localparam logic [2:0] KIND_UNTERM  = 3'd4;
	localparam logic [2:0] KIND_STRAY   = 3'd5;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

endpackage

// ===== sv/sxt_ifs.sv =====
interface sxt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface sxt_token_if #(
	parameter int POS_BITS  = 32,
	parameter int LINE_BITS = 24,
	parameter int COL_BITS  = 16
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           token_kind;
	logic [2:0]           bracket_code;
	logic [POS_BITS-1:0]  start_offset;
	logic [POS_BITS-1:0]  end_offset;
	logic [LINE_BITS-1:0] start_line;
	logic [COL_BITS-1:0]  start_column;
	logic                 last_of_run;

	modport source (output valid, output token_kind, output bracket_code,
		output start_offset, output end_offset, output start_line,
		output start_column, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input bracket_code,
		input start_offset, input end_offset, input start_line,
		input start_column, input last_of_run, output ready);
endinterface

interface sxt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sxt_pkg::CFG_IDX_W-1:0]    index;
	logic [sxt_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/sexpr_byte_tokenizer.sv =====
// S-expression byte tokenizer.
// byte_in carries one source byte per transaction, with end_of_text set on
// the last byte of a text; the next byte starts a new text at offset 0,
// line 1, column 1. tok_out carries one token span per transaction, and
// last_of_run marks the final token caused by a given byte. cfg writes the
// bracket set, the two literal delimiters, the escape byte and the comment
// byte; write it only while no text is in flight.
// A byte is taken into an input register and resolved from there once the
// result queue has room for its tokens, which are written into that queue
// and offered on tok_out from its head. One byte per cycle is sustained
// while the queue has room; a byte that closes an atom and is itself a
// one-byte token yields two tokens, and the single output port drains them
// at one per cycle. A four-entry result queue sits between the resolve logic
// and tok_out: byte_in keeps flowing while tok_out is stalled until the queue
// lacks room for two tokens, then ready drops until tok_out drains.
// Reset restores the default delimiter set and clears all positions and the
// result queue; no tokens are lost or repeated across stalls.
module sexpr_byte_tokenizer #(
	parameter int POS_BITS  = 32,
	parameter int LINE_BITS = 24,
	parameter int COL_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sxt_byte_if.sink   byte_in,
	sxt_token_if.source tok_out,
	sxt_cfg_if.sink    cfg
);
	import sxt_pkg::*;

	localparam int RES_W = 7 + 2 * POS_BITS + LINE_BITS + COL_BITS;
	localparam int COL_LO  = 1;
	localparam int LINE_LO = COL_LO + COL_BITS;
	localparam int END_LO  = LINE_LO + LINE_BITS;
	localparam int STA_LO  = END_LO + POS_BITS;
	localparam int CODE_LO = STA_LO + POS_BITS;
	localparam int KIND_LO = CODE_LO + 3;

	logic             valid_s1;
	logic [7:0]       text_byte_s1;
	logic             eot_s1;
	logic             fire;
	logic             room;
	logic [1:0]       push_n;
	logic [RES_W-1:0] res0, res1, head;

	assign fire          = valid_s1 && room;
	assign byte_in.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			text_byte_s1 <= byte_in.text_byte;
			eot_s1       <= byte_in.end_of_text;
		end
	end

	sxt_core #(
		.POS_BITS (POS_BITS),
		.LINE_BITS(LINE_BITS),
		.COL_BITS (COL_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.fire       (fire),
		.text_byte  (text_byte_s1),
		.end_of_text(eot_s1),
		.push_n     (push_n),
		.res0       (res0),
		.res1       (res1)
	);

	sxt_fifo #(
		.W(RES_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.din0     (res0),
		.din1     (res1),
		.room     (room),
		.out_valid(tok_out.valid),
		.out_ready(tok_out.ready),
		.dout     (head)
	);

	assign tok_out.token_kind   = head[KIND_LO +: 3];
	assign tok_out.bracket_code = head[CODE_LO +: 3];
	assign tok_out.start_offset = head[STA_LO +: POS_BITS];
	assign tok_out.end_offset   = head[END_LO +: POS_BITS];
	assign tok_out.start_line   = head[LINE_LO +: LINE_BITS];
	assign tok_out.start_column = head[COL_LO +: COL_BITS];
	assign tok_out.last_of_run  = head[0];

endmodule

// ===== sv/sxt_core.sv =====
`include "sexpr_byte_tokenizer_assert.svh"

module sxt_core #(
	parameter int POS_BITS  = 32,
	parameter int LINE_BITS = 24,
	parameter int COL_BITS  = 16,
	localparam int RES_W    = 7 + 2 * POS_BITS + LINE_BITS + COL_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	sxt_cfg_if.sink          cfg,
	input  logic             fire,
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	output logic [1:0]       push_n,
	output logic [RES_W-1:0] res0,
	output logic [RES_W-1:0] res1
);
	import sxt_pkg::*;

	typedef struct packed {
		logic [2:0]           kind;
		logic [2:0]           code;
		logic [POS_BITS-1:0]  s;
		logic [POS_BITS-1:0]  e;
		logic [LINE_BITS-1:0] line;
		logic [COL_BITS-1:0]  col;
		logic                 last;
	} res_t;

	logic [47:0] brackets_q;
	logic [7:0]  str_dlm_q, chr_dlm_q, esc_q, cmt_q;

	mode_t                mode_q, mode_d;
	logic                 lit_char_q, lit_char_d;
	logic                 pesc_q, pesc_d;
	logic [POS_BITS-1:0]  pos_q, pos_d, tpos_q, tpos_d;
	logic [LINE_BITS-1:0] line_q, line_d, tline_q, tline_d;
	logic [COL_BITS-1:0]  col_q, col_d, tcol_q, tcol_d;

	logic [POS_BITS-1:0] end_w;
	logic                br_hit;
	logic [2:0]          br_idx;
	logic                c_space, c_br, c_atom, c_lit, c_cmt, c_stray;
	logic                lit_close;
	logic                st_emit;
	res_t                st, r0, r1;
	logic [1:0]          n_w;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brackets_q <= RST_BRACKETS;
			str_dlm_q  <= RST_STRING_DLM;
			chr_dlm_q  <= RST_CHAR_DLM;
			esc_q      <= RST_ESCAPE;
			cmt_q      <= RST_COMMENT;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_BRACKETS:   brackets_q <= cfg.data;
				CFG_STRING_DLM: str_dlm_q  <= cfg.data[7:0];
				CFG_CHAR_DLM:   chr_dlm_q  <= cfg.data[7:0];
				CFG_ESCAPE:     esc_q      <= cfg.data[7:0];
				CFG_COMMENT:    cmt_q      <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	assign end_w = (pos_q == '1) ? pos_q : pos_q + POS_BITS'(1);

	// Descending scan so the lowest matching bracket slot wins.
	always_comb begin
		br_hit = 1'b0;
		br_idx = 3'd0;
		for (int k = 5; k >= 0; k--) begin
			if (brackets_q[8*k +: 8] == text_byte) begin
				br_hit = 1'b1;
				br_idx = 3'(k);
			end
		end
	end

	always_comb begin
		c_space = is_space(text_byte);
		c_br    = !c_space && br_hit;
		c_atom  = !c_space && !br_hit && text_byte != str_dlm_q && text_byte != chr_dlm_q
			&& text_byte != esc_q && text_byte != cmt_q;
		c_lit   = !c_space && !br_hit && (text_byte == str_dlm_q || text_byte == chr_dlm_q);
		c_cmt   = !c_space && !br_hit && !c_lit && text_byte == cmt_q;
		c_stray = !c_space && !br_hit && !c_atom && !c_lit && !c_cmt;
		lit_close = !pesc_q && text_byte == (lit_char_q ? chr_dlm_q : str_dlm_q);
	end

	// Token that a byte arriving between tokens produces on its own.
	always_comb begin
		st      = '0;
		st.s    = pos_q;
		st.e    = end_w;
		st.line = line_q;
		st.col  = col_q;
		st.last = 1'b1;
		st_emit = 1'b0;
		if (c_br) begin
			st_emit = 1'b1;
			st.kind = KIND_BRACKET;
			st.code = br_idx;
		end else if (c_atom && end_of_text) begin
			st_emit = 1'b1;
			st.kind = KIND_ATOM;
		end else if (c_lit && end_of_text) begin
			st_emit = 1'b1;
			st.kind = KIND_UNTERM;
		end else if (c_stray) begin
			st_emit = 1'b1;
			st.kind = KIND_STRAY;
		end
	end

	// Result selection.
	always_comb begin
		r0      = '0;
		r0.s    = tpos_q;
		r0.e    = end_w;
		r0.line = tline_q;
		r0.col  = tcol_q;
		r0.last = 1'b1;
		r1      = st;
		n_w     = 2'd0;
		case (mode_q)
			MODE_ATOM: begin
				r0.kind = KIND_ATOM;
				if (c_atom) begin
					if (end_of_text) n_w = 2'd1;
				end else begin
					r0.e    = pos_q;
					r0.last = !st_emit;
					n_w     = st_emit ? 2'd2 : 2'd1;
				end
			end
			MODE_LITERAL: begin
				if (lit_close) begin
					r0.kind = lit_char_q ? KIND_CHAR : KIND_STRING;
					n_w     = 2'd1;
				end else if (end_of_text) begin
					r0.kind = KIND_UNTERM;
					n_w     = 2'd1;
				end
			end
			MODE_COMMENT: n_w = 2'd0;
			MODE_DEAD:    n_w = 2'd0;
			default: begin
				r0  = st;
				n_w = st_emit ? 2'd1 : 2'd0;
			end
		endcase
	end

	assign push_n = fire ? n_w : 2'd0;
	assign res0   = r0;
	assign res1   = r1;

	// Next-state logic.
	always_comb begin
		mode_d     = mode_q;
		lit_char_d = lit_char_q;
		pesc_d     = pesc_q;
		tpos_d     = tpos_q;
		tline_d    = tline_q;
		tcol_d     = tcol_q;
		case (mode_q)
			MODE_LITERAL: begin
				if (lit_close) mode_d = MODE_IDLE;
				pesc_d = (text_byte == esc_q);
			end
			MODE_COMMENT: begin
				if (text_byte == NEWLINE) mode_d = MODE_IDLE;
			end
			MODE_DEAD: mode_d = MODE_DEAD;
			default: begin
				if (mode_q != MODE_ATOM || !c_atom) begin
					if (c_atom && !end_of_text)
						mode_d = MODE_ATOM;
					else if (c_lit && !end_of_text)
						mode_d = MODE_LITERAL;
					else if (c_cmt)
						mode_d = MODE_COMMENT;
					else if (c_stray)
						mode_d = MODE_DEAD;
					else
						mode_d = MODE_IDLE;
					if (c_atom || c_lit) begin
						tpos_d  = pos_q;
						tline_d = line_q;
						tcol_d  = col_q;
					end
					if (c_lit) begin
						lit_char_d = (text_byte != str_dlm_q);
						pesc_d     = (text_byte == esc_q);
					end
				end
			end
		endcase

		if (end_of_text) begin
			mode_d     = MODE_IDLE;
			lit_char_d = 1'b0;
			pesc_d     = 1'b0;
			pos_d      = '0;
			line_d     = LINE_BITS'(1);
			col_d      = COL_BITS'(1);
			tpos_d     = '0;
			tline_d    = LINE_BITS'(1);
			tcol_d     = COL_BITS'(1);
		end else begin
			pos_d = end_w;
			if (text_byte == NEWLINE) begin
				line_d = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);
				col_d  = COL_BITS'(1);
			end else begin
				line_d = line_q;
				col_d  = (col_q == '1) ? col_q : col_q + COL_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			lit_char_q <= 1'b0;
			pesc_q     <= 1'b0;
			pos_q      <= '0;
			line_q     <= LINE_BITS'(1);
			col_q      <= COL_BITS'(1);
			tpos_q     <= '0;
			tline_q    <= LINE_BITS'(1);
			tcol_q     <= COL_BITS'(1);
		end else if (fire) begin
			mode_q     <= mode_d;
			lit_char_q <= lit_char_d;
			pesc_q     <= pesc_d;
			pos_q      <= pos_d;
			line_q     <= line_d;
			col_q      <= col_d;
			tpos_q     <= tpos_d;
			tline_q    <= tline_d;
			tcol_q     <= tcol_d;
		end
	end

	`SXT_ASSERT_NOW(a_dead_silent, clk, arst_n, fire && mode_q == MODE_DEAD, push_n == 2'd0,
		"tokenizer emitted a token while discarding text")
	`SXT_ASSERT_NOW(a_pair_from_atom, clk, arst_n, push_n == 2'd2, mode_q == MODE_ATOM,
		"two tokens from one byte outside an atom")
	`SXT_ASSERT_NEXT(a_eot_rewind, clk, arst_n, fire && end_of_text,
		pos_q == '0 && line_q == LINE_BITS'(1) && col_q == COL_BITS'(1) && mode_q == MODE_IDLE,
		"position not rewound after end of text")

endmodule

// ===== sv/sxt_fifo.sv =====
`include "sexpr_byte_tokenizer_assert.svh"

module sxt_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [1:0]   push_n,
	input  logic [W-1:0] din0,
	input  logic [W-1:0] din1,
	output logic         room,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] dout
);
	import sxt_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   count_q;
	logic             pop;

	// Room is kept for a full pair so the core never has to split a byte.
	assign room      = count_q <= (PTR_W+1)'(DEPTH - 2);
	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign dout      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= din0;
		if (push_n == 2'd2) mem_q[wr_q + PTR_W'(1)] <= din1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push_n);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			count_q <= count_q + (PTR_W+1)'(push_n) - (PTR_W+1)'(pop);
		end
	end

	`SXT_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= (PTR_W+1)'(DEPTH),
		"result queue count out of range")
	`SXT_ASSERT_NOW(a_no_overrun, clk, arst_n, push_n != 2'd0, room,
		"result queue written without room")
	`SXT_ASSERT_NEXT(a_count_track, clk, arst_n, 1'b1,
		count_q == $past(count_q) + (PTR_W+1)'($past(push_n)) - (PTR_W+1)'($past(pop)),
		"result queue count lost track of transactions")

endmodule
